// File: rtl/hcc_pkg.sv
// Package for the hex colour command RGB PWM block.
// Holds the transaction payload types, character codes and the hex digit decoder.
// No dependencies; used by hcc_line and hex_color_command_rgb_pwm.
package hcc_pkg;

	// Item kinds carried in the cmd field.
	localparam logic CmdTick = 1'b0;
	localparam logic CmdByte = 1'b1;

	// Characters that steer the command line parser.
	localparam logic [7:0] ChCr  = 8'h0D;
	localparam logic [7:0] ChLf  = 8'h0A;
	localparam logic [7:0] ChXUp = 8'h58;
	localparam logic [7:0] ChXLo = 8'h78;

	// Width of a stored duty as seen on the save port.
	localparam int SaveW = 7;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic             red_pin;
		logic             green_pin;
		logic             blue_pin;
		logic             save_valid;
		logic [SaveW-1:0] save_red;
		logic [SaveW-1:0] save_green;
		logic [SaveW-1:0] save_blue;
		logic             user_mode;
	} result_t;

	// Save request and mode produced by the line parser for one item.
	typedef struct packed {
		logic             save_valid;
		logic [SaveW-1:0] save_red;
		logic [SaveW-1:0] save_green;
		logic [SaveW-1:0] save_blue;
		logic             user_mode;
	} line_res_t;

	// Hex digit value of an ASCII character; anything else counts as zero.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

endpackage

// File: rtl/hex_color_command_rgb_pwm.sv
// Top level of the hex colour command RGB PWM driver.
// Depends on hcc_pkg, hcc_line and hcc_pwm.
//
// Channel  Direction  Signals                            Payload
// item     in         item_valid, item_stall, item       hcc_pkg::item_t (cmd, rx_byte)
// result   out        result_valid, result_stall, result hcc_pkg::result_t (pins, save, mode)
//
// Each accepted transaction lands in an input register (stage 1). From there one
// pass of short logic (a counter compare, a nibble shift, a constant multiply and
// a divide-by-255 reciprocal) updates the block state and fills the result register.
// The result register and result_valid load from stage 1 when the transaction
// commits, which a held result_stall can delay; one transaction per cycle is
// sustained as long as result_stall stays low.
// Reset clears the counter, duties, pins, line state and both valid flags.
// A held result_stall freezes the result register and then stage 1; item_stall
// rises only when stage 1 is full and cannot move on.
module hex_color_command_rgb_pwm #(
	parameter int PERIOD = 100
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  hcc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output hcc_pkg::result_t result
);

	// The counter must be able to hold PERIOD itself for the wrap compare.
	localparam int CntW = $clog2(PERIOD + 1);

	logic               valid_s1;
	hcc_pkg::item_t     item_s1;
	logic               result_valid_q;
	hcc_pkg::result_t   result_q;

	logic               advance;
	logic               commit;
	logic               tick;
	logic [CntW-1:0]    red_duty;
	logic [CntW-1:0]    green_duty;
	logic [CntW-1:0]    blue_duty;
	logic [2:0]         pins_nx;
	hcc_pkg::line_res_t line_res;
	hcc_pkg::result_t   result_nx;

	// Stage 1 moves into the result register whenever that register is empty or
	// its transaction is being taken in this cycle. The state of the block changes
	// exactly when a stage 1 transaction commits.
	assign advance    = !result_valid_q || !result_stall;
	assign commit     = valid_s1 && advance;
	assign tick       = commit && (item_s1.cmd == hcc_pkg::CmdTick);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	hcc_line #(
		.PERIOD(PERIOD),
		.CntW  (CntW)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.item      (item_s1),
		.red_duty  (red_duty),
		.green_duty(green_duty),
		.blue_duty (blue_duty),
		.res       (line_res)
	);

	// The PWM timer sees the duties held before this transaction, so a line end
	// only affects the pins from the next tick on.
	hcc_pwm #(
		.PERIOD(PERIOD),
		.CntW  (CntW)
	) u_pwm (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.red_duty  (red_duty),
		.green_duty(green_duty),
		.blue_duty (blue_duty),
		.pins_nx   (pins_nx)
	);

	always_comb begin
		result_nx.red_pin    = pins_nx[0];
		result_nx.green_pin  = pins_nx[1];
		result_nx.blue_pin   = pins_nx[2];
		result_nx.save_valid = line_res.save_valid;
		result_nx.save_red   = line_res.save_red;
		result_nx.save_green = line_res.save_green;
		result_nx.save_blue  = line_res.save_blue;
		result_nx.user_mode  = line_res.user_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= result_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A clear line leaves user mode and must request zeros only.
	a_clear_saves_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.save_valid && !result.user_mode
		|-> result.save_red == '0 && result.save_green == '0 && result.save_blue == '0)
		else $error("clear line requested a nonzero save");

	// Every accepted transaction occupies stage 1 in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> valid_s1)
		else $error("accepted transaction missing from stage 1");

	// A blocked stage 1 keeps its transaction until the result side frees up.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stage 1 transaction lost while blocked");

endmodule

// File: rtl/hcc_line.sv
// Command line parser: collects hex nibbles into a colour and scales it to duties.
// Depends on hcc_pkg for the item and line result types and character codes.
module hcc_line #(
	parameter int PERIOD = 100,
	parameter int CntW   = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   commit,
	input  hcc_pkg::item_t         item,
	output logic [CntW-1:0]        red_duty,
	output logic [CntW-1:0]        green_duty,
	output logic [CntW-1:0]        blue_duty,
	output hcc_pkg::line_res_t     res
);

	logic [23:0]     accum_q;
	logic            clear_seen_q;
	logic            nonempty_q;
	logic            user_q;
	logic [CntW-1:0] red_q;
	logic [CntW-1:0] green_q;
	logic [CntW-1:0] blue_q;

	logic            is_byte;
	logic            is_eol;
	logic            is_x;
	logic            line_end;
	logic            set_colour;
	logic [CntW-1:0] red_new;
	logic [CntW-1:0] green_new;
	logic [CntW-1:0] blue_new;
	logic            user_nx;

	// Scales one colour byte by PERIOD/255, truncating. x/255 for a 16-bit x is
	// (x + x/256 + 1)/256, which is exact for every x up to 65534.
	function automatic logic [CntW-1:0] scale_byte(input logic [7:0] b);
		logic [15:0] prod;
		logic [16:0] t;
		prod = 16'(b) * 16'(PERIOD);
		t    = 17'(prod) + 17'(prod[15:8]) + 17'd1;
		return CntW'(t[15:8]);
	endfunction

	always_comb begin
		is_byte    = (item.cmd == hcc_pkg::CmdByte);
		is_eol     = (item.rx_byte == hcc_pkg::ChCr) || (item.rx_byte == hcc_pkg::ChLf);
		is_x       = (item.rx_byte == hcc_pkg::ChXUp) || (item.rx_byte == hcc_pkg::ChXLo);
		line_end   = is_byte && is_eol && nonempty_q;
		set_colour = line_end && !clear_seen_q;
		red_new    = scale_byte(accum_q[23:16]);
		green_new  = scale_byte(accum_q[15:8]);
		blue_new   = scale_byte(accum_q[7:0]);

		user_nx = user_q;
		if (line_end) begin
			user_nx = !clear_seen_q;
		end

		res.save_valid = line_end;
		res.save_red   = set_colour ? hcc_pkg::SaveW'(red_new)   : '0;
		res.save_green = set_colour ? hcc_pkg::SaveW'(green_new) : '0;
		res.save_blue  = set_colour ? hcc_pkg::SaveW'(blue_new)  : '0;
		res.user_mode  = user_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			clear_seen_q <= 1'b0;
			nonempty_q   <= 1'b0;
			user_q       <= 1'b0;
			red_q        <= '0;
			green_q      <= '0;
			blue_q       <= '0;
		end else if (commit && is_byte) begin
			if (is_eol) begin
				if (nonempty_q) begin
					if (!clear_seen_q) begin
						red_q   <= red_new;
						green_q <= green_new;
						blue_q  <= blue_new;
					end
					user_q       <= user_nx;
					accum_q      <= '0;
					clear_seen_q <= 1'b0;
					nonempty_q   <= 1'b0;
				end
			end else begin
				nonempty_q <= 1'b1;
				if (is_x) begin
					clear_seen_q <= 1'b1;
				end else begin
					accum_q <= {accum_q[19:0], hcc_pkg::hex_nibble(item.rx_byte)};
				end
			end
		end
	end

	assign red_duty   = red_q;
	assign green_duty = green_q;
	assign blue_duty  = blue_q;

endmodule

// File: rtl/hcc_pwm.sv
// Three-channel PWM timer: period counter and pin levels, advanced once per tick.
// Depends on no package; duties come from the line parser.
module hcc_pwm #(
	parameter int PERIOD = 100,
	parameter int CntW   = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick,
	input  logic [CntW-1:0] red_duty,
	input  logic [CntW-1:0] green_duty,
	input  logic [CntW-1:0] blue_duty,
	output logic [2:0]      pins_nx
);

	logic [CntW-1:0] cnt_q;
	logic [2:0]      pins_q;
	logic [CntW-1:0] cnt_inc;
	logic            wrap;
	logic [CntW-1:0] cnt_nx;

	// Pin bit 0 is red, bit 1 green, bit 2 blue.
	always_comb begin
		cnt_inc = cnt_q + CntW'(1);
		wrap    = (cnt_inc >= CntW'(PERIOD));
		cnt_nx  = wrap ? '0 : cnt_inc;
		pins_nx = pins_q;
		if (tick) begin
			if (cnt_inc >= red_duty)   pins_nx[0] = 1'b0;
			if (cnt_inc >= green_duty) pins_nx[1] = 1'b0;
			if (cnt_inc >= blue_duty)  pins_nx[2] = 1'b0;
			if (wrap) begin
				if (red_duty != '0)   pins_nx[0] = 1'b1;
				if (green_duty != '0) pins_nx[1] = 1'b1;
				if (blue_duty != '0)  pins_nx[2] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pins_q <= '0;
		end else if (tick) begin
			cnt_q  <= cnt_nx;
			pins_q <= pins_nx;
		end
	end

endmodule
